@@ hdl/bdim_pkg.sv @@
// ----------------------------------------------------------------------------
// bdim_pkg
// shared types, codes and defaults of the block distribution id mapper
// ----------------------------------------------------------------------------
package bdim_pkg;

    // defaults for the top level parameters
    localparam int MAX_GROUPS_DEF = 16;
    localparam int ID_BITS_DEF    = 32;
    localparam int PE_BITS_DEF    = 16;

    // fixed field widths
    localparam int DATA_W   = 48;
    localparam int SIZE_W   = 32;
    localparam int PE_W     = 16;
    localparam int SPAN_W   = 16;
    localparam int STRIDE_W = 32;
    localparam int DIV_N_W  = 48;
    localparam int DIV_D_W  = 33;
    localparam int QUEUE_DEPTH = 2;

    // operation codes
    localparam logic [1:0] OP_ADD     = 2'd0;
    localparam logic [1:0] OP_ID2SLOT = 2'd1;
    localparam logic [1:0] OP_SLOT2ID = 2'd2;
    localparam logic [1:0] OP_LOC2ID  = 2'd3;

    // status codes
    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_FULL   = 3'd1;
    localparam logic [2:0] ST_BAD_PE = 3'd2;
    localparam logic [2:0] ST_BAD_ID = 3'd3;
    localparam logic [2:0] ST_OVF    = 3'd4;

    typedef struct packed {
        logic [1:0]        op;
        logic [SIZE_W-1:0] group_size;
        logic [PE_W-1:0]   first_pe;
        logic [PE_W-1:0]   last_pe;
        logic [DATA_W-1:0] item_id;
        logic [PE_W-1:0]   pe_index;
    } t_in_item;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic [2:0]        status;
    } t_out_item;

    // classified command held in the queue
    typedef struct packed {
        t_in_item   item;
        logic [2:0] pre_status;
    } t_cmd;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_stat;

    typedef struct packed {
        logic               start;
        logic [DIV_N_W-1:0] dividend;
        logic [DIV_D_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic [DIV_N_W-1:0] quot;
        logic [DIV_D_W-1:0] rem;
    } t_div_rsp;

endpackage

@@ hdl/bdim_front.sv @@
// ----------------------------------------------------------------------------
// bdim_front
// accepts input transfers, checks PE fields and pushes commands into the queue
// ----------------------------------------------------------------------------
module bdim_front import bdim_pkg::*; #(
    parameter int PE_BITS = PE_BITS_DEF
) (
    input  logic            i_valid,
    input  t_in_item        i_item,
    input  logic [PE_W-1:0] i_np,
    input  t_q_stat         i_q,
    output logic            o_stall,
    output logic            o_push,
    output t_cmd            o_cmd
);

    function automatic logic bad_pe(input logic [PE_W-1:0] pe, input logic [PE_W-1:0] np);
        logic [PE_W:0] ext;
        ext = {1'b0, pe};
        return (pe >= np) || ((ext >> PE_BITS) != '0);
    endfunction

    // transfer whenever the queue has room
    assign o_stall = i_q.full;
    assign o_push  = i_valid && !i_q.full;

    // early status for PE range errors
    always_comb begin
        o_cmd.item       = i_item;
        o_cmd.pre_status = ST_OK;
        case (i_item.op)
            OP_ADD: begin
                if (bad_pe(i_item.first_pe, i_np) || bad_pe(i_item.last_pe, i_np)) begin
                    o_cmd.pre_status = ST_BAD_PE;
                end
            end
            OP_LOC2ID: begin
                if (bad_pe(i_item.pe_index, i_np)) begin
                    o_cmd.pre_status = ST_BAD_PE;
                end
            end
            default: o_cmd.pre_status = ST_OK;
        endcase
    end

endmodule

@@ hdl/bdim_queue.sv @@
// ----------------------------------------------------------------------------
// bdim_queue
// short command queue between the front and the back
// ----------------------------------------------------------------------------
module bdim_queue import bdim_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_cmd    i_cmd,
    input  logic    i_pop,
    output t_cmd    o_cmd,
    output t_q_stat o_stat
);

    localparam int PW = $clog2(QUEUE_DEPTH);

    t_cmd          r_buf [QUEUE_DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [PW:0]   r_cnt;

    assign o_cmd       = r_buf[r_rd];
    assign o_stat.empty = (r_cnt == '0);
    assign o_stat.full  = (r_cnt == (PW+1)'(QUEUE_DEPTH));

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + PW'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + PW'(1);
            end
            r_cnt <= r_cnt + (PW+1)'(i_push) - (PW+1)'(i_pop);
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wr] <= i_cmd;
        end
    end

endmodule

@@ hdl/bdim_div.sv @@
// ----------------------------------------------------------------------------
// bdim_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module bdim_div import bdim_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    localparam int CNT_W = $clog2(DIV_N_W + 1);

    logic               r_busy;
    logic               r_done;
    logic [CNT_W-1:0]   r_cnt;
    logic [DIV_N_W-1:0] r_quot;
    logic [DIV_D_W-1:0] r_rem;
    logic [DIV_D_W-1:0] r_den;
    logic [DIV_D_W:0]   rem_sh;
    logic [DIV_D_W+1:0] diff;
    logic               ge;

    // trial subtract
    always_comb begin
        rem_sh = {r_rem, r_quot[DIV_N_W-1]};
        diff   = {1'b0, rem_sh} - (DIV_D_W+2)'(r_den);
        ge     = !diff[DIV_D_W+1];
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;
    assign o_rsp.rem  = r_rem;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIV_N_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quot <= i_req.dividend;
            r_rem  <= '0;
            r_den  <= i_req.divisor;
        end else if (r_busy) begin
            r_quot <= {r_quot[DIV_N_W-2:0], ge};
            r_rem  <= ge ? diff[DIV_D_W-1:0] : rem_sh[DIV_D_W-1:0];
        end
    end

endmodule

@@ hdl/bdim_back.sv @@
// ----------------------------------------------------------------------------
// bdim_back
// group table and sequencer that carries out the four operations
// ----------------------------------------------------------------------------
module bdim_back import bdim_pkg::*; #(
    parameter int MAX_GROUPS = MAX_GROUPS_DEF,
    parameter int ID_BITS    = ID_BITS_DEF,
    parameter int PE_BITS    = PE_BITS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [PE_W-1:0] i_np,
    input  t_cmd            i_cmd,
    input  t_q_stat         i_q,
    output logic            o_pop,
    output t_div_req        o_div,
    input  t_div_rsp        i_div,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output t_out_item       o_out
);

    localparam int AW = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
    localparam int CW = $clog2(MAX_GROUPS + 1);
    localparam logic [DATA_W:0] ID_MAX = (DATA_W+1)'((64'd1 << ID_BITS) - 64'd1);

    typedef struct packed {
        logic [SIZE_W-1:0]  neurons;
        logic [PE_BITS-1:0] first;
        logic [PE_BITS-1:0] last;
        logic [SPAN_W-1:0]  span;
        logic [SIZE_W-1:0]  q;
        logic [SPAN_W-1:0]  r;
        logic [ID_BITS-1:0] base;
    } t_entry;

    typedef enum logic [4:0] {
        S_IDLE, S_ADD, S_F_RD, S_F_CHK, S_F_THR, S_F_DIV0, S_F_DIV1, S_F_PE,
        S_W_RD, S_W_ACC, S_F_MUL, S_F_FIN, S_P_DIV, S_L_RD, S_L_ACC, S_L_MUL,
        S_L_FIN, S_OUT
    } t_state;

    t_entry mem [MAX_GROUPS];
    t_entry r_ent;
    logic   mem_we;
    t_entry mem_wdata;

    t_state              r_state,  n_state;
    logic [CW-1:0]       r_count,  n_count;
    logic [ID_BITS-1:0]  r_total,  n_total;
    logic [STRIDE_W-1:0] r_stride, n_stride;
    logic [AW-1:0]       r_idx,    n_idx;
    logic [AW-1:0]       r_g,      n_g;
    t_cmd                r_cmd,    n_cmd;
    logic [PE_W-1:0]     r_pe,     n_pe;
    logic [SPAN_W-1:0]   r_span,   n_span;
    logic [DATA_W-1:0]   r_loc,    n_loc;
    logic [DATA_W:0]     r_cum,    n_cum;
    logic [DATA_W:0]     r_prev,   n_prev;
    logic signed [18:0]  r_pos,    n_pos;
    logic [DIV_D_W-1:0]  r_w,      n_w;
    logic [DIV_D_W-1:0]  r_thr,    n_thr;
    logic                r_br,     n_br;
    logic [DIV_D_W-1:0]  r_off,    n_off;
    logic [DATA_W-1:0]   r_prod,   n_prod;
    t_out_item           r_res,    n_res;
    t_out_item           r_out,    n_out;
    logic                r_ovalid, n_ovalid;
    t_div_req            r_div,    n_div;

    // share of the current table entry on PE r_pe
    logic [PE_W:0]      sh_f, sh_l, sh_p;
    logic               sh_in;
    logic signed [18:0] sh_pos;
    logic               sh_lt_r;
    logic [DIV_D_W-1:0] sh_n;
    logic [DATA_W:0]    new_cum;

    always_comb begin
        sh_f   = (PE_W+1)'(r_ent.first);
        sh_l   = (PE_W+1)'(r_ent.last);
        sh_p   = (PE_W+1)'(r_pe);
        sh_in  = (sh_f <= sh_l) ? (sh_f <= sh_p && sh_p <= sh_l) : (sh_f <= sh_p || sh_p <= sh_l);
        sh_pos = (sh_f <= sh_p) ? 19'(sh_p - sh_f) : 19'(sh_p) + 19'(i_np) - 19'(sh_f);
        sh_lt_r = !sh_pos[18] && (sh_pos < 19'(r_ent.r));
        sh_n   = sh_in ? DIV_D_W'(r_ent.q) + DIV_D_W'(sh_lt_r) : '0;
        new_cum = r_cum + (DATA_W+1)'(sh_n);
    end

    assign o_div       = r_div;
    assign o_out_valid = r_ovalid;
    assign o_out       = r_out;

    // next state
    always_comb begin
        logic [SPAN_W-1:0]   span;
        logic [DIV_D_W-1:0]  ceil_sh;
        logic [DATA_W:0]     tot_sum;
        logic [DIV_D_W-1:0]  str_sum;
        logic [DATA_W:0]     end_id;
        logic [PE_W:0]       p;
        logic signed [51:0]  l_prod;
        logic [DATA_W-1:0]   mn;

        n_state  = r_state;
        n_count  = r_count;
        n_total  = r_total;
        n_stride = r_stride;
        n_idx    = r_idx;
        n_g      = r_g;
        n_cmd    = r_cmd;
        n_pe     = r_pe;
        n_span   = r_span;
        n_loc    = r_loc;
        n_cum    = r_cum;
        n_prev   = r_prev;
        n_pos    = r_pos;
        n_w      = r_w;
        n_thr    = r_thr;
        n_br     = r_br;
        n_off    = r_off;
        n_prod   = r_prod;
        n_res    = r_res;
        n_out    = r_out;
        n_ovalid = r_ovalid;
        n_div    = '0;
        o_pop    = 1'b0;
        mem_we   = 1'b0;

        span    = '0;
        ceil_sh = DIV_D_W'(i_div.quot[SIZE_W-1:0]) + DIV_D_W'(i_div.rem[SPAN_W-1:0] != '0);
        tot_sum = (DATA_W+1)'(r_total) + (DATA_W+1)'(r_cmd.item.group_size);
        str_sum = DIV_D_W'(r_stride) + ceil_sh;
        end_id  = (DATA_W+1)'(r_ent.base) + (DATA_W+1)'(r_ent.neurons);
        p       = r_br ? (PE_W+1)'(r_ent.r) + (PE_W+1)'(i_div.quot[SPAN_W-1:0])
                       : (PE_W+1)'(i_div.quot[SPAN_W-1:0]);
        l_prod  = r_pos * $signed({1'b0, r_ent.q});
        mn      = (r_pos[18] || !(r_pos < 19'(r_ent.r))) ? DATA_W'(r_ent.r)
                                                          : DATA_W'(r_pos[17:0]);

        mem_wdata.neurons = r_cmd.item.group_size;
        mem_wdata.first   = r_cmd.item.first_pe[PE_BITS-1:0];
        mem_wdata.last    = r_cmd.item.last_pe[PE_BITS-1:0];
        mem_wdata.span    = r_span;
        mem_wdata.q       = i_div.quot[SIZE_W-1:0];
        mem_wdata.r       = i_div.rem[SPAN_W-1:0];
        mem_wdata.base    = r_total;

        // output register drains
        if (r_ovalid && !i_out_stall) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (!i_q.empty) begin
                    o_pop = 1'b1;
                    n_cmd = i_cmd;
                    n_res = '0;
                    n_state = S_OUT;
                    if (i_cmd.pre_status != ST_OK) begin
                        n_res.status = i_cmd.pre_status;
                    end else begin
                        case (i_cmd.item.op)
                            OP_ADD: begin
                                if (r_count >= CW'(MAX_GROUPS)) begin
                                    n_res.status = ST_FULL;
                                end else begin
                                    if (i_cmd.item.first_pe <= i_cmd.item.last_pe) begin
                                        span = i_cmd.item.last_pe - i_cmd.item.first_pe
                                             + SPAN_W'(1);
                                    end else begin
                                        span = i_np - (i_cmd.item.first_pe
                                             - i_cmd.item.last_pe - SPAN_W'(1));
                                    end
                                    n_span = span;
                                    n_div.start    = 1'b1;
                                    n_div.dividend = DIV_N_W'(i_cmd.item.group_size);
                                    n_div.divisor  = DIV_D_W'(span);
                                    n_state = S_ADD;
                                end
                            end
                            OP_ID2SLOT: begin
                                if (i_cmd.item.item_id >= DATA_W'(r_total)) begin
                                    n_res.status = ST_BAD_ID;
                                end else begin
                                    n_idx   = '0;
                                    n_state = S_F_RD;
                                end
                            end
                            OP_SLOT2ID: begin
                                if (r_stride == '0) begin
                                    n_res.status = ST_BAD_ID;
                                end else begin
                                    n_div.start    = 1'b1;
                                    n_div.dividend = i_cmd.item.item_id;
                                    n_div.divisor  = DIV_D_W'(r_stride);
                                    n_state = S_P_DIV;
                                end
                            end
                            default: begin
                                n_pe  = i_cmd.item.pe_index;
                                n_loc = i_cmd.item.item_id;
                                if (r_count == '0) begin
                                    n_res.status = ST_BAD_ID;
                                end else begin
                                    n_idx   = '0;
                                    n_cum   = '0;
                                    n_state = S_L_RD;
                                end
                            end
                        endcase
                    end
                end
            end
            // add group: split size over the span, then check totals
            S_ADD: begin
                if (i_div.done) begin
                    if (tot_sum > ID_MAX || str_sum > DIV_D_W'(33'h0_FFFF_FFFF)) begin
                        n_res.status = ST_OVF;
                    end else begin
                        mem_we       = 1'b1;
                        n_count      = r_count + CW'(1);
                        n_total      = ID_BITS'(tot_sum);
                        n_stride     = str_sum[STRIDE_W-1:0];
                        n_res.value  = DATA_W'(r_total);
                    end
                    n_state = S_OUT;
                end
            end
            // id to slot: find the owning group, then its PE and offset
            S_F_RD: n_state = S_F_CHK;
            S_F_CHK: begin
                if ((CW'(r_idx) < r_count - CW'(1)) &&
                    ((DATA_W+1)'(r_cmd.item.item_id) >= end_id)) begin
                    n_idx   = r_idx + AW'(1);
                    n_state = S_F_RD;
                end else begin
                    n_w     = DIV_D_W'(r_cmd.item.item_id - DATA_W'(r_ent.base));
                    n_state = S_F_THR;
                end
            end
            S_F_THR: begin
                n_thr   = DIV_D_W'((DIV_D_W'(r_ent.q) + DIV_D_W'(1)) * DIV_D_W'(r_ent.r));
                n_state = S_F_DIV0;
            end
            S_F_DIV0: begin
                if (r_w < r_thr) begin
                    n_br           = 1'b0;
                    n_div.start    = 1'b1;
                    n_div.dividend = DIV_N_W'(r_w);
                    n_div.divisor  = DIV_D_W'(r_ent.q) + DIV_D_W'(1);
                    n_state        = S_F_DIV1;
                end else if (r_ent.q != '0) begin
                    n_br           = 1'b1;
                    n_div.start    = 1'b1;
                    n_div.dividend = DIV_N_W'(r_w - r_thr);
                    n_div.divisor  = DIV_D_W'(r_ent.q);
                    n_state        = S_F_DIV1;
                end else begin
                    n_off          = '0;
                    n_div.start    = 1'b1;
                    n_div.dividend = DIV_N_W'((PE_W+1)'(r_ent.r) + (PE_W+1)'(r_ent.first));
                    n_div.divisor  = DIV_D_W'(i_np);
                    n_state        = S_F_PE;
                end
            end
            S_F_DIV1: begin
                if (i_div.done) begin
                    n_off          = i_div.rem;
                    n_div.start    = 1'b1;
                    n_div.dividend = DIV_N_W'(p + (PE_W+1)'(r_ent.first));
                    n_div.divisor  = DIV_D_W'(i_np);
                    n_state        = S_F_PE;
                end
            end
            S_F_PE: begin
                if (i_div.done) begin
                    n_pe    = i_div.rem[PE_W-1:0];
                    n_g     = r_idx;
                    n_idx   = '0;
                    n_cum   = '0;
                    n_state = (r_idx == '0) ? S_F_MUL : S_W_RD;
                end
            end
            // sum shares of earlier groups on the target PE
            S_W_RD: n_state = S_W_ACC;
            S_W_ACC: begin
                n_cum   = new_cum;
                n_idx   = r_idx + AW'(1);
                n_state = (r_idx + AW'(1) == r_g) ? S_F_MUL : S_W_RD;
            end
            S_F_MUL: begin
                n_prod  = DATA_W'(r_pe * r_stride);
                n_state = S_F_FIN;
            end
            S_F_FIN: begin
                n_res.value = r_prod + DATA_W'(r_cum) + DATA_W'(r_off);
                n_state     = S_OUT;
            end
            // slot to id: split slot into PE and local index
            S_P_DIV: begin
                if (i_div.done) begin
                    if (i_div.quot >= DATA_W'(i_np)) begin
                        n_res.status = ST_BAD_PE;
                        n_state      = S_OUT;
                    end else if (r_count == '0) begin
                        n_res.status = ST_BAD_ID;
                        n_state      = S_OUT;
                    end else begin
                        n_pe    = i_div.quot[PE_W-1:0];
                        n_loc   = DATA_W'(i_div.rem);
                        n_idx   = '0;
                        n_cum   = '0;
                        n_state = S_L_RD;
                    end
                end
            end
            // local index to id: walk groups on the PE
            S_L_RD: n_state = S_L_ACC;
            S_L_ACC: begin
                if ((DATA_W+1)'(r_loc) < new_cum) begin
                    n_pos   = sh_pos;
                    n_prev  = r_cum;
                    n_state = S_L_MUL;
                end else begin
                    n_cum = new_cum;
                    if (CW'(r_idx) == r_count - CW'(1)) begin
                        n_res.status = ST_BAD_ID;
                        n_state      = S_OUT;
                    end else begin
                        n_idx   = r_idx + AW'(1);
                        n_state = S_L_RD;
                    end
                end
            end
            S_L_MUL: begin
                n_prod  = l_prod[DATA_W-1:0];
                n_state = S_L_FIN;
            end
            S_L_FIN: begin
                n_res.value = r_prod + DATA_W'(r_ent.base) + mn
                            + DATA_W'((DATA_W+1)'(r_loc) - r_prev);
                n_state     = S_OUT;
            end
            // hand result to the output register
            S_OUT: begin
                if (!r_ovalid || !i_out_stall) begin
                    n_ovalid = 1'b1;
                    n_out    = r_res;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_total  <= '0;
            r_stride <= '0;
            r_ovalid <= 1'b0;
            r_div    <= '0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_total  <= n_total;
            r_stride <= n_stride;
            r_ovalid <= n_ovalid;
            r_div    <= n_div;
        end
        r_idx  <= n_idx;
        r_g    <= n_g;
        r_cmd  <= n_cmd;
        r_pe   <= n_pe;
        r_span <= n_span;
        r_loc  <= n_loc;
        r_cum  <= n_cum;
        r_prev <= n_prev;
        r_pos  <= n_pos;
        r_w    <= n_w;
        r_thr  <= n_thr;
        r_br   <= n_br;
        r_off  <= n_off;
        r_prod <= n_prod;
        r_res  <= n_res;
        r_out  <= n_out;
    end

    // group table
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_count[AW-1:0]] <= mem_wdata;
        end
        r_ent <= mem[r_idx];
    end

endmodule

@@ hdl/block_distribution_id_mapper.sv @@
// ----------------------------------------------------------------------------
// block_distribution_id_mapper
// maps neuron ids, global slots and local indexes over a block-distributed
// group table
// ----------------------------------------------------------------------------
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+------------------
//  input   | in        | i_in_valid / o_in_stall  | i_in_data
//  output  | out       | o_out_valid / i_out_stall| o_out_data
//  config  | in        | i_cfg_we                 | i_cfg_data
//
//  add group runs one divide on the bit-serial divider.
//  slot to id runs one divide and then one table walk; local to id walks
//  the table only; id to slot runs up to two divides and up to two table walks
//  (owner search, then shares on the pe).
//  every walk reads each group through the table's registered read.
//  a two-entry queue takes transfers while the back end is busy.
//  reset clears the group count, totals and num_pes (to 1); no clearing pass.
// ----------------------------------------------------------------------------
module block_distribution_id_mapper import bdim_pkg::*; #(
    parameter int MAX_GROUPS = MAX_GROUPS_DEF,
    parameter int ID_BITS    = ID_BITS_DEF,
    parameter int PE_BITS    = PE_BITS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [PE_W-1:0] i_cfg_data,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  t_in_item        i_in_data,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output t_out_item       o_out_data
);

    logic [PE_W-1:0] r_num_pes;
    logic [PE_W-1:0] np;
    logic            push;
    logic            pop;
    t_cmd            cmd_in;
    t_cmd            cmd_out;
    t_q_stat         q_stat;
    t_div_req        div_req;
    t_div_rsp        div_rsp;

    // pe count register, zero acts as one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_pes <= PE_W'(1);
        end else if (i_cfg_we) begin
            r_num_pes <= i_cfg_data;
        end
    end
    assign np = (r_num_pes == '0) ? PE_W'(1) : r_num_pes;

    bdim_front #(.PE_BITS(PE_BITS)) u_front (
        .i_valid (i_in_valid),
        .i_item  (i_in_data),
        .i_np    (np),
        .i_q     (q_stat),
        .o_stall (o_in_stall),
        .o_push  (push),
        .o_cmd   (cmd_in)
    );

    bdim_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd_in),
        .i_pop   (pop),
        .o_cmd   (cmd_out),
        .o_stat  (q_stat)
    );

    bdim_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    bdim_back #(
        .MAX_GROUPS (MAX_GROUPS),
        .ID_BITS    (ID_BITS),
        .PE_BITS    (PE_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_np        (np),
        .i_cmd       (cmd_out),
        .i_q         (q_stat),
        .o_pop       (pop),
        .o_div       (div_req),
        .i_div       (div_rsp),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out_data)
    );

endmodule

@@ hdl/bdim_checker.sv @@
// ----------------------------------------------------------------------------
// bdim_checker
// port-level checks of the block distribution id mapper
// ----------------------------------------------------------------------------
module bdim_checker import bdim_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_data
);

    // no result right after reset
    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // input side is ready right after reset
    a_reset_ready: assert property (@(posedge i_clk) !i_rst_n |=> !o_in_stall)
        else $error("input stalled after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    // error results carry a zero value
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status != ST_OK |-> o_out_data.value == '0)
        else $error("error result with nonzero value");

    // status stays within the defined codes
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.status <= ST_OVF)
        else $error("undefined status code");

endmodule

bind block_distribution_id_mapper bdim_checker u_bdim_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

@@ verif/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the block distribution id mapper: a predictor keeps
// its own group table and checks every output transfer, while directed and
// random operations run under several PE counts with random idle and stall
// ----------------------------------------------------------------------------
module testbench import bdim_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam bit [63:0] ID_LIMIT      = (64'd1 << ID_BITS_DEF) - 64'd1;
    localparam bit [63:0] PE_RANGE      = 64'd1 << PE_BITS_DEF;
    localparam bit [63:0] STRIDE_LIMIT  = 64'hFFFF_FFFF;
    localparam bit [63:0] MASK48        = 64'hFFFF_FFFF_FFFF;
    localparam int        WATCHDOG_LIMIT = 20000;
    localparam int        ITEMS_PER_PHASE = 232;

    // group table predictor and store of expected results
    class id_map_scoreboard;
        bit [63:0] pes;
        int        n_groups;
        bit [63:0] g_size[MAX_GROUPS_DEF];
        bit [63:0] g_first[MAX_GROUPS_DEF];
        bit [63:0] g_last[MAX_GROUPS_DEF];
        bit [63:0] g_span[MAX_GROUPS_DEF];
        bit [63:0] g_base[MAX_GROUPS_DEF];
        bit [63:0] total;
        bit [63:0] stride;
        t_out_item expected_q[$];
        int        mismatches;
        int        results_seen;
        int        status_seen[8];

        function new();
            pes = 1;
            n_groups = 0;
            total = 0;
            stride = 0;
            mismatches = 0;
            results_seen = 0;
        endfunction

        function bit [63:0] eff_pes();
            return (pes == 0) ? 64'd1 : pes;
        endfunction

        // neurons of group g on a PE, and the PE's position in the range
        function bit [63:0] pe_share(int g, bit [63:0] pe, output bit [63:0] pos);
            bit [63:0] f;
            bit [63:0] l;
            bit        hit;
            f = g_first[g];
            l = g_last[g];
            hit = (f <= l) ? (f <= pe && pe <= l) : (f <= pe || pe <= l);
            pos = (f <= pe) ? pe - f : pe + (eff_pes() - f);
            if (!hit) return 0;
            return g_size[g] / g_span[g] + ((pos < g_size[g] % g_span[g]) ? 1 : 0);
        endfunction

        // local index on a PE back to a neuron id
        function bit local_to_neuron(bit [63:0] loc_idx, bit [63:0] pe,
                                     output bit [63:0] id);
            bit [63:0] prev;
            bit [63:0] cum;
            bit [63:0] pos;
            bit [63:0] q;
            bit [63:0] r;
            cum = 0;
            id = 0;
            for (int g = 0; g < n_groups; g++) begin
                prev = cum;
                cum += pe_share(g, pe, pos);
                if (loc_idx < cum) begin
                    q = g_size[g] / g_span[g];
                    r = g_size[g] % g_span[g];
                    id = (g_base[g] + pos * q + ((pos < r) ? pos : r) + (loc_idx - prev))
                         & MASK48;
                    return 1;
                end
            end
            return 0;
        endfunction

        function void note_transfer(t_in_item it);
            bit [63:0] sz, fpe, lpe, item, pei, np;
            bit [63:0] span, ceil_share, q, r, w, thr, p, off, pe, loc, pos, value;
            bit [2:0]  status;
            int        g;
            t_out_item res;
            sz = it.group_size;
            fpe = it.first_pe;
            lpe = it.last_pe;
            item = it.item_id;
            pei = it.pe_index;
            np = eff_pes();
            value = 0;
            status = ST_OK;
            case (it.op)
                OP_ADD: begin
                    if (fpe >= np || lpe >= np || fpe >= PE_RANGE || lpe >= PE_RANGE) begin
                        status = ST_BAD_PE;
                    end else if (n_groups >= MAX_GROUPS_DEF) begin
                        status = ST_FULL;
                    end else begin
                        span = (fpe <= lpe) ? lpe - fpe + 1 : np - (fpe - lpe - 1);
                        ceil_share = (sz + span - 1) / span;
                        if (total + sz > ID_LIMIT || stride + ceil_share > STRIDE_LIMIT) begin
                            status = ST_OVF;
                        end else begin
                            g_size[n_groups] = sz;
                            g_first[n_groups] = fpe;
                            g_last[n_groups] = lpe;
                            g_span[n_groups] = span;
                            g_base[n_groups] = total;
                            n_groups++;
                            value = total;
                            total += sz;
                            stride += ceil_share;
                        end
                    end
                end
                OP_ID2SLOT: begin
                    if (item >= total) begin
                        status = ST_BAD_ID;
                    end else begin
                        g = 0;
                        while (g < n_groups - 1 && item >= g_base[g] + g_size[g]) g++;
                        q = g_size[g] / g_span[g];
                        r = g_size[g] % g_span[g];
                        w = item - g_base[g];
                        thr = (q + 1) * r;
                        if (w < thr) begin
                            p = w / (q + 1);
                            off = w % (q + 1);
                        end else if (q != 0) begin
                            p = r + (w - thr) / q;
                            off = (w - thr) % q;
                        end else begin
                            p = r;
                            off = 0;
                        end
                        pe = (p + g_first[g]) % np;
                        loc = 0;
                        for (int k = 0; k < g; k++) loc += pe_share(k, pe, pos);
                        value = pe * stride + loc + off;
                    end
                end
                OP_SLOT2ID: begin
                    if (stride == 0) begin
                        status = ST_BAD_ID;
                    end else if (item / stride >= np) begin
                        status = ST_BAD_PE;
                    end else if (!local_to_neuron(item % stride, item / stride, value)) begin
                        status = ST_BAD_ID;
                    end
                end
                default: begin
                    if (pei >= np || pei >= PE_RANGE) begin
                        status = ST_BAD_PE;
                    end else if (!local_to_neuron(item, pei, value)) begin
                        status = ST_BAD_ID;
                    end
                end
            endcase
            if (status != ST_OK) value = 0;
            res.value = value[47:0];
            res.status = status;
            status_seen[status]++;
            expected_q.push_back(res);
        endfunction

        function void check_result(t_out_item got);
            t_out_item exp_res;
            results_seen++;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: value %0h status %0d",
                             got.value, got.status);
                return;
            end
            exp_res = expected_q.pop_front();
            if (got.value !== exp_res.value || got.status !== exp_res.status) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch on result %0d: expected value %0h status %0d, got %0h %0d",
                             results_seen, exp_res.value, exp_res.status,
                             got.value, got.status);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic      i_clk;
    logic      i_rst_n;
    logic      i_cfg_we;
    logic [PE_W-1:0] i_cfg_data;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_item  i_in_data;
    logic      o_out_valid;
    logic      i_out_stall;
    t_out_item o_out_data;

    id_map_scoreboard sb;
    int  idle_cycles = 0;
    int  items_sent;
    bit  calm;
    int  stall_left;

    block_distribution_id_mapper i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // clock
    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // transfer monitor on both channels
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                sb.note_transfer(i_in_data);
            end
            if (o_out_valid && !i_out_stall) begin
                sb.check_result(o_out_data);
            end
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // watchdog
    initial begin
        while (idle_cycles < WATCHDOG_LIMIT) @(posedge i_clk);
        $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    // receiver stall pattern
    initial begin
        int r;
        i_out_stall = 1'b0;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (calm) begin
                i_out_stall = 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_out_stall = 1'b1;
            end else begin
                r = $urandom % 100;
                if (r < 60) begin
                    i_out_stall = 1'b0;
                end else if (r < 92) begin
                    stall_left = $urandom_range(0, 3);
                    i_out_stall = 1'b1;
                end else begin
                    stall_left = $urandom_range(20, 80);
                    i_out_stall = 1'b1;
                end
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom % 100;
        if (calm || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic bit [47:0] rand48();
        return {$urandom, $urandom};
    endfunction

    // one input transfer, starting and ending at a falling edge
    task automatic send_item(t_in_item it);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_data = it;
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        items_sent++;
        @(negedge i_clk);
    endtask

    // drop valid at once so the last transfer is not repeated
    task automatic wait_drain();
        i_in_valid = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_pes(bit [15:0] pes);
        i_cfg_data = pes;
        i_cfg_we = 1'b1;
        sb.pes = pes;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    function automatic t_in_item make_op(logic [1:0] op, bit [31:0] sz, bit [15:0] fpe,
                                         bit [15:0] lpe, bit [47:0] item, bit [15:0] pei);
        t_in_item it;
        it.op = op;
        it.group_size = sz;
        it.first_pe = fpe;
        it.last_pe = lpe;
        it.item_id = item;
        it.pe_index = pei;
        return it;
    endfunction

    task automatic run_directed();
        send_item(make_op(OP_ID2SLOT, 0, 0, 0, 0, 0));
        send_item(make_op(OP_SLOT2ID, 0, 0, 0, 0, 0));
        send_item(make_op(OP_LOC2ID, 0, 0, 0, 0, 0));
        send_item(make_op(OP_LOC2ID, 0, 0, 0, 0, 8));
        send_item(make_op(OP_LOC2ID, 0, 0, 0, 0, 16'hFFFF));
        // bad PE on add
        send_item(make_op(OP_ADD, 5, 8, 0, 0, 0));
        send_item(make_op(OP_ADD, 5, 0, 16'hFFFF, 0, 0));
        // wrapping range, empty group, full range, overflow
        send_item(make_op(OP_ADD, 13, 6, 1, 0, 0));
        send_item(make_op(OP_ADD, 0, 2, 2, 0, 0));
        send_item(make_op(OP_ADD, 20, 0, 7, 0, 0));
        send_item(make_op(OP_ADD, 32'hFFFF_FFFF, 0, 7, 0, 0));
        send_item(make_op(OP_ADD, 5, 7, 7, 0, 0));
        send_item(make_op(OP_ID2SLOT, 0, 0, 0, 0, 0));
        send_item(make_op(OP_ID2SLOT, 0, 0, 0, 12, 0));
        send_item(make_op(OP_ID2SLOT, 0, 0, 0, 13, 0));
        send_item(make_op(OP_ID2SLOT, 0, 0, 0, 37, 0));
        send_item(make_op(OP_ID2SLOT, 0, 0, 0, 38, 0));
        send_item(make_op(OP_SLOT2ID, 0, 0, 0, 0, 0));
        send_item(make_op(OP_SLOT2ID, 0, 0, 0, 48'(sb.stride * 6 + 2), 0));
        send_item(make_op(OP_SLOT2ID, 0, 0, 0, 48'(sb.stride * 8), 0));
        send_item(make_op(OP_SLOT2ID, 0, 0, 0, 48'hFFFF_FFFF_FFFF, 0));
        send_item(make_op(OP_LOC2ID, 0, 0, 0, 0, 6));
        send_item(make_op(OP_LOC2ID, 0, 0, 0, 2, 3));
        send_item(make_op(OP_LOC2ID, 0, 0, 0, 100, 7));
    endtask

    // random item, mostly well formed lookups against the current table
    function automatic t_in_item make_random();
        t_in_item  it;
        bit [63:0] np, span;
        int        r;
        np = sb.eff_pes();
        it.op = $urandom;
        it.group_size = $urandom;
        it.first_pe = $urandom;
        it.last_pe = $urandom;
        it.item_id = rand48();
        it.pe_index = $urandom;
        r = $urandom % 100;
        if (r < 5) begin
            it.op = OP_ADD;
            if ($urandom % 8 != 0) begin
                it.first_pe = $urandom % np;
                it.last_pe = $urandom % np;
            end
            r = $urandom % 10;
            if (r < 7) it.group_size = $urandom_range(0, 300);
            else if (r < 9) it.group_size = $urandom_range(0, 100000);
        end else if (r < 85) begin
            it.op = $urandom_range(1, 3);
            span = sb.stride + 2;
            case (it.op)
                OP_ID2SLOT: if (sb.total != 0) it.item_id = rand48() % (sb.total + 1);
                OP_SLOT2ID: it.item_id = (($urandom % np) * sb.stride + rand48() % span)
                                         & MASK48;
                default: begin
                    it.pe_index = $urandom % np;
                    it.item_id = rand48() % span;
                end
            endcase
        end else if (it.op == OP_ADD) begin
            it.op = OP_LOC2ID;
        end
        return it;
    endfunction

    initial begin
        bit [15:0] pes_list[7];
        sb = new();
        pes_list = '{16'd8, 16'd0, 16'd1, 16'd65535, 16'd5, 16'd300, 16'd3};
        items_sent = 0;
        calm = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // each phase runs under one PE count
        foreach (pes_list[ph]) begin
            if (ph != 0) wait_drain();
            calm = (ph == 2);
            write_pes(pes_list[ph]);
            if (ph == 0) run_directed();
            repeat (ITEMS_PER_PHASE) send_item(make_random());
        end
        wait_drain();
        repeat (200) @(posedge i_clk);

        $display("covered %0d transfers over %0d PE counts, %0d groups in table",
                 items_sent, $size(pes_list), sb.n_groups);
        $display("status mix ok/full/bad pe/bad id/overflow: %0d/%0d/%0d/%0d/%0d",
                 sb.status_seen[ST_OK], sb.status_seen[ST_FULL],
                 sb.status_seen[ST_BAD_PE], sb.status_seen[ST_BAD_ID],
                 sb.status_seen[ST_OVF]);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("%0d mismatches, %0d results outstanding", sb.mismatches, sb.pending());
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

@@ block_distribution_id_mapper.f @@
hdl/bdim_pkg.sv
hdl/bdim_front.sv
hdl/bdim_queue.sv
hdl/bdim_div.sv
hdl/bdim_back.sv
hdl/block_distribution_id_mapper.sv
hdl/bdim_checker.sv
verif/testbench.sv
